>>> rtl/magma_block_encrypt_macros.svh
// Assertion macros for the checker file, magma_checker.sv.
`ifndef MAGMA_BLOCK_ENCRYPT_MACROS_SVH
`define MAGMA_BLOCK_ENCRYPT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MAGMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MAGMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/magma_pkg.sv
// Magma cipher constants, S-box table and round function.
`default_nettype none

package magma_pkg;

	localparam int ROUNDS    = 32;
	localparam int KEY_WORDS = 8;
	localparam int ROT       = 11;
	localparam int HALF_W    = 32;
	localparam int KEY_IDX_W = $clog2(KEY_WORDS);

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	// Row 0 acts on the most significant nibble, row 7 on the least.
	localparam logic [3:0] SBOX [0:7][0:15] = '{
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1}
	};

	// Key schedule: k0..k7 three times, then k7..k0.
	function automatic key_idx_t key_sel(input int r);
		if (r < ROUNDS - KEY_WORDS) begin
			return key_idx_t'(r % KEY_WORDS);
		end
		return key_idx_t'(ROUNDS - 1 - r);
	endfunction

	// Key add mod 2^32, nibble substitution, rotate left.
	function automatic half_t round_fn(input half_t half, input half_t key);
		half_t s;
		half_t t;
		s = half + key;
		t = '0;
		for (int n = 0; n < 8; n++) begin
			t[(28 - 4*n) +: 4] = SBOX[n][s[(28 - 4*n) +: 4]];
		end
		return {t[HALF_W-ROT-1:0], t[HALF_W-1:HALF_W-ROT]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/magma_cell.sv
// One Feistel round stage with its own valid bit and backpressure.
`default_nettype none

module magma_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	input  wire magma_pkg::half_t up_hi,
	input  wire magma_pkg::half_t up_lo,
	output logic                  up_ready,
	input  wire magma_pkg::half_t key,
	output logic                  dn_valid,
	output magma_pkg::half_t      dn_hi,
	output magma_pkg::half_t      dn_lo,
	input  wire logic             dn_ready
);

	logic             valid_q;
	magma_pkg::half_t hi_q;
	magma_pkg::half_t lo_q;

	// Loads when empty or when the held item moves on.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			hi_q <= up_lo;
			lo_q <= magma_pkg::round_fn(up_lo, key) ^ up_hi;
		end
	end

	assign dn_valid = valid_q;
	assign dn_hi    = hi_q;
	assign dn_lo    = lo_q;

endmodule

`default_nettype wire

>>> rtl/magma_block_encrypt.sv
// Magma (GOST R 34.12-2015) 64-bit block encryption, one round per stage.
//
// Usage:
//   in channel  : in_valid / in_ready, payload plaintext_block.
//   out channel : out_valid / out_ready, payload ciphertext_block.
//   key port    : wr_en / wr_index / wr_data writes key word k[wr_index];
//                 change keys only while no item is in flight.
// Path: an accepted item is registered once per round in a row of 32
//   round cells, and out_valid comes from the last cell's register.
// Throughput: one item per cycle while out_ready stays high; every cell takes
//   a new item as soon as its own item moves on.
// Stall: each cell holds its item while the next one is full and stalled.
//   Empty cells behind a stalled result still fill, so up to 32 items can
//   be taken while out_ready is low; in_ready then drops.
// The last cell doubles as the output register; its halves are read out
//   in swapped order, which undoes the exchange after round 32.
// Reset: all cells empty, key words cleared to zero.
`default_nettype none

module magma_block_encrypt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [63:0]                     plaintext_block,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [63:0]                          ciphertext_block,
	input  wire logic                            wr_en,
	input  wire magma_pkg::key_idx_t             wr_index,
	input  wire magma_pkg::half_t                wr_data
);

	// Key registers k0..k7
	magma_pkg::half_t key_q [magma_pkg::KEY_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < magma_pkg::KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (wr_en) begin
			key_q[wr_index] <= wr_data;
		end
	end

	// Links between cells; link 0 is the input, link ROUNDS the output.
	logic             vld [magma_pkg::ROUNDS+1];
	logic             rdy [magma_pkg::ROUNDS+1];
	magma_pkg::half_t hi  [magma_pkg::ROUNDS+1];
	magma_pkg::half_t lo  [magma_pkg::ROUNDS+1];

	assign vld[0] = in_valid;
	assign hi[0]  = plaintext_block[63:32];
	assign lo[0]  = plaintext_block[31:0];
	assign in_ready = rdy[0];
	assign rdy[magma_pkg::ROUNDS] = out_ready;

	for (genvar r = 0; r < magma_pkg::ROUNDS; r++) begin : g_round
		magma_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[r]),
			.up_hi    (hi[r]),
			.up_lo    (lo[r]),
			.up_ready (rdy[r]),
			.key      (key_q[magma_pkg::key_sel(r)]),
			.dn_valid (vld[r+1]),
			.dn_hi    (hi[r+1]),
			.dn_lo    (lo[r+1]),
			.dn_ready (rdy[r+1])
		);
	end

	// No exchange after the last round: swap back on the way out.
	assign out_valid        = vld[magma_pkg::ROUNDS];
	assign ciphertext_block = {lo[magma_pkg::ROUNDS], hi[magma_pkg::ROUNDS]};

endmodule

`default_nettype wire

>>> rtl/magma_checker.sv
// Port-level checks for magma_block_encrypt, bound to the top level.
`default_nettype none

`include "magma_block_encrypt_macros.svh"

module magma_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [63:0] plaintext_block,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] ciphertext_block
);

	// A waiting result stays until taken.
	`MAGMA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

	// A waiting result keeps its value.
	`MAGMA_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(ciphertext_block), "result changed while stalled")

	// With the output side free, the row never pushes back.
	`MAGMA_ASSERT_IMP(a_ready_free, out_ready, in_ready, "input stalled while output free")

	// An empty last cell means room all along the row.
	`MAGMA_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind magma_block_encrypt magma_checker u_magma_checker (.*);

`default_nettype wire
